// File: sv/adif_field_tokenizer_assert.svh
// Assertion macros used by the tokenizer RTL.
`ifndef ADIF_FIELD_TOKENIZER_ASSERT_SVH
`define ADIF_FIELD_TOKENIZER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define AFTOK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define AFTOK_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

// File: sv/aftok_pkg.sv
package aftok_pkg;

  localparam int unsigned SizeW = 20;
  localparam int unsigned MaxLenW = 16;

  localparam logic [SizeW-1:0] SIZE_SAT = 20'hFFFFF;

  localparam logic [7:0] CHAR_LT    = 8'h3C;
  localparam logic [7:0] CHAR_GT    = 8'h3E;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_EOI  = 1'b1;

  localparam logic [1:0] KIND_NAME = 2'd0;
  localparam logic [1:0] KIND_TYPE = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;
  localparam logic [1:0] KIND_END  = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NAME_LONG = 3'd1;
  localparam logic [2:0] ST_SIZE_LONG = 3'd2;
  localparam logic [2:0] ST_TYPE_LONG = 3'd3;
  localparam logic [2:0] ST_DATA_LONG = 3'd4;
  localparam logic [2:0] ST_EOI       = 3'd5;

  typedef struct packed {
    logic       opcode;
    logic [7:0] byte_in;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]       token_kind;
    logic [7:0]       token_byte;
    logic [2:0]       field_status;
    logic [SizeW-1:0] declared_length;
  } out_beat_t;

  typedef struct packed {
    logic clear;
    logic step;
  } size_ctrl_t;

  typedef struct packed {
    logic [SizeW-1:0] value;
    logic             is_zero;
    logic             over_max;
  } size_stat_t;

endpackage

// File: sv/adif_field_tokenizer.sv
// Tokenizer for ADIF tag-length-value streams (<name:size:type>data). Takes one byte per
// beat and returns zero or one token per beat: name, type and data bytes, and a field end
// carrying a status and the decimal size read from the tag. The size is read as decimal,
// saturated at 2^20-1, and checked against max_data_length (written on the cfg channel,
// always ready, reset 65535; write only while idle). A byte is accepted every cycle unless
// input is stalled; its token is registered on the output in the next cycle. The single
// output register sets the pace: input is stalled only while a held token is stalled.
module adif_field_tokenizer #(
  parameter int unsigned NAME_LEN_MAX = 32,
  parameter int unsigned SIZE_LEN_MAX = 8,
  parameter int unsigned TYPE_LEN_MAX = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  aftok_pkg::in_beat_t            in_beat_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output aftok_pkg::out_beat_t           out_beat_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [aftok_pkg::MaxLenW-1:0]  cfg_data_i
);
  import aftok_pkg::*;

  `include "adif_field_tokenizer_assert.svh"

  localparam int unsigned NameCntW = $clog2(NAME_LEN_MAX + 1);
  localparam int unsigned SizeCntW = $clog2(SIZE_LEN_MAX + 1);
  localparam int unsigned TypeCntW = $clog2(TYPE_LEN_MAX + 1);

  localparam logic [2:0] PH_SEEK = 3'd0;
  localparam logic [2:0] PH_NAME = 3'd1;
  localparam logic [2:0] PH_SIZE = 3'd2;
  localparam logic [2:0] PH_TYPE = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;

  logic [2:0]          phase_q, phase_d;
  logic [NameCntW-1:0] name_cnt_q, name_cnt_d;
  logic [SizeCntW-1:0] size_cnt_q, size_cnt_d;
  logic [TypeCntW-1:0] type_cnt_q, type_cnt_d;
  logic [SizeW-1:0]    left_q, left_d;
  logic [MaxLenW-1:0]  max_len_q;
  logic                out_valid_q, out_valid_d;
  out_beat_t           out_beat_q, out_beat_d;

  logic       in_fire;
  logic       out_free;
  logic       emit;
  out_beat_t  tok;
  size_ctrl_t size_ctrl;
  size_stat_t size_stat;
  logic [7:0] b;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !out_free;
  assign in_fire     = in_valid_i && out_free;
  assign cfg_ready_o = 1'b1;
  assign b           = in_beat_i.byte_in;

  aftok_size u_size (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (size_ctrl),
    .byte_i    (b),
    .max_len_i (max_len_q),
    .stat_o    (size_stat)
  );

  always_comb begin
    phase_d    = phase_q;
    name_cnt_d = name_cnt_q;
    size_cnt_d = size_cnt_q;
    type_cnt_d = type_cnt_q;
    left_d     = left_q;
    size_ctrl  = '0;
    emit       = 1'b0;
    tok        = '0;
    if (in_fire) begin
      if (in_beat_i.opcode == OP_EOI) begin
        emit              = 1'b1;
        tok.token_kind    = KIND_END;
        tok.field_status  = ST_EOI;
        phase_d           = PH_SEEK;
      end else begin
        case (phase_q)
          PH_SEEK: begin
            if (b == CHAR_LT) begin
              phase_d         = PH_NAME;
              name_cnt_d      = '0;
              size_cnt_d      = '0;
              type_cnt_d      = '0;
              left_d          = '0;
              size_ctrl.clear = 1'b1;
            end
          end
          PH_NAME: begin
            if (b == CHAR_GT) begin
              emit           = 1'b1;
              tok.token_kind = KIND_END;
              phase_d        = PH_SEEK;
            end else if (b == CHAR_COLON) begin
              phase_d = PH_SIZE;
            end else if (name_cnt_q < NameCntW'(NAME_LEN_MAX)) begin
              name_cnt_d     = name_cnt_q + NameCntW'(1);
              emit           = 1'b1;
              tok.token_kind = KIND_NAME;
              tok.token_byte = b;
            end else begin
              emit             = 1'b1;
              tok.token_kind   = KIND_END;
              tok.field_status = ST_NAME_LONG;
              phase_d          = PH_SEEK;
            end
          end
          PH_SIZE: begin
            if (b == CHAR_COLON || b == CHAR_GT) begin
              if (size_stat.is_zero) begin
                emit           = 1'b1;
                tok.token_kind = KIND_END;
                phase_d        = PH_SEEK;
              end else if (size_stat.over_max) begin
                emit             = 1'b1;
                tok.token_kind   = KIND_END;
                tok.field_status = ST_DATA_LONG;
                phase_d          = PH_SEEK;
              end else begin
                left_d  = size_stat.value;
                phase_d = (b == CHAR_COLON) ? PH_TYPE : PH_DATA;
              end
            end else if (size_cnt_q < SizeCntW'(SIZE_LEN_MAX)) begin
              size_cnt_d     = size_cnt_q + SizeCntW'(1);
              size_ctrl.step = 1'b1;
            end else begin
              emit             = 1'b1;
              tok.token_kind   = KIND_END;
              tok.field_status = ST_SIZE_LONG;
              phase_d          = PH_SEEK;
            end
          end
          PH_TYPE: begin
            if (b == CHAR_GT) begin
              phase_d = PH_DATA;
            end else if (type_cnt_q < TypeCntW'(TYPE_LEN_MAX)) begin
              type_cnt_d     = type_cnt_q + TypeCntW'(1);
              emit           = 1'b1;
              tok.token_kind = KIND_TYPE;
              tok.token_byte = b;
            end else begin
              emit             = 1'b1;
              tok.token_kind   = KIND_END;
              tok.field_status = ST_TYPE_LONG;
              phase_d          = PH_SEEK;
            end
          end
          PH_DATA: begin
            if (left_q != '0) begin
              left_d         = left_q - SizeW'(1);
              emit           = 1'b1;
              tok.token_kind = KIND_DATA;
              tok.token_byte = b;
            end else begin
              emit           = 1'b1;
              tok.token_kind = KIND_END;
              phase_d        = PH_SEEK;
            end
          end
          default: begin
            phase_d = PH_SEEK;
          end
        endcase
      end
      if (emit && tok.token_kind == KIND_END) begin
        tok.declared_length = size_stat.value;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_beat_d  = out_beat_q;
    if (out_free) begin
      out_valid_d = emit;
      out_beat_d  = tok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SEEK;
      name_cnt_q  <= '0;
      size_cnt_q  <= '0;
      type_cnt_q  <= '0;
      left_q      <= '0;
      max_len_q   <= '1;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      name_cnt_q  <= name_cnt_d;
      size_cnt_q  <= size_cnt_d;
      type_cnt_q  <= type_cnt_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_len_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_beat_q <= out_beat_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  `AFTOK_ASSERT_IMP(a_stall_only_when_held, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  `AFTOK_ASSERT_IMP(a_token_no_status, clk_i, rst_ni,
    out_valid_o && out_beat_o.token_kind != KIND_END,
    out_beat_o.field_status == ST_OK && out_beat_o.declared_length == '0)
  `AFTOK_ASSERT_IMP(a_end_no_byte, clk_i, rst_ni,
    out_valid_o && out_beat_o.token_kind == KIND_END,
    out_beat_o.token_byte == '0 && out_beat_o.field_status <= ST_EOI)
  `AFTOK_ASSERT_NXT(a_eoi_to_seek, clk_i, rst_ni,
    in_fire && in_beat_i.opcode == OP_EOI,
    phase_q == PH_SEEK && out_valid_o && out_beat_o.field_status == ST_EOI)

endmodule

// File: sv/aftok_size.sv
module aftok_size (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  aftok_pkg::size_ctrl_t           ctrl_i,
  input  logic [7:0]                      byte_i,
  input  logic [aftok_pkg::MaxLenW-1:0]   max_len_i,
  output aftok_pkg::size_stat_t           stat_o
);
  import aftok_pkg::*;

  logic [SizeW-1:0] value_q, value_d;
  logic             stop_q, stop_d;
  logic             is_digit;
  logic [SizeW+3:0] value_ext;
  logic [SizeW+3:0] acc;

  assign is_digit  = (byte_i >= CHAR_ZERO) && (byte_i <= CHAR_NINE);
  assign value_ext = {4'b0, value_q};
  // times ten plus digit, saturate
  assign acc = (value_ext << 3) + (value_ext << 1) + {{(SizeW){1'b0}}, byte_i[3:0]};

  always_comb begin
    value_d = value_q;
    stop_d  = stop_q;
    if (ctrl_i.clear) begin
      value_d = '0;
      stop_d  = 1'b0;
    end else if (ctrl_i.step) begin
      if (!stop_q && is_digit) begin
        value_d = (acc > {4'b0, SIZE_SAT}) ? SIZE_SAT : acc[SizeW-1:0];
      end else begin
        stop_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
      stop_q  <= 1'b0;
    end else begin
      value_q <= value_d;
      stop_q  <= stop_d;
    end
  end

  assign stat_o.value    = value_q;
  assign stat_o.is_zero  = (value_q == '0);
  assign stat_o.over_max = (value_q > {{(SizeW-MaxLenW){1'b0}}, max_len_i});

endmodule
